FILE: src/hvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_pkg: shared types and constants for the heightmap vertex normal block
// Grid limits, field widths, register indexes and the front-to-back item.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int MAX_ROW     = 1024;
  localparam int HEIGHT_BITS = 9;
  localparam int COL_W       = $clog2(MAX_ROW);
  localparam int LEN_W       = 11;
  localparam int STEP_W      = 7;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 1;
  // weighted sum of six heights (weights 1,1,2,2,1,1) fits in three more bits; four are used
  localparam int SUM_W       = HEIGHT_BITS + 4;
  localparam int PROD_W      = SUM_W + STEP_W + 1;
  localparam int NXZ_W       = 19;
  localparam int NY_W        = 16;
  localparam int MIN_LEN     = 3;

  localparam logic [COL_W-1:0] ROW_SAT = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic signed [HEIGHT_BITS-1:0] height_t;

  // one height with the two heights above it, plus result tag and vertex column and row
  typedef struct packed {
    height_t          h;
    height_t          up1;
    height_t          up2;
    logic             emit;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;
  } hvn_item_t;

endpackage
`default_nettype wire

FILE: src/hvn_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_front: input side of the heightmap vertex normal block
// Counts columns and rows, reads and updates the line store, tags items.
// ----------------------------------------------------------------------------
module hvn_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire hvn_pkg::height_t           height,
  input  wire logic                       frame_start,
  input  wire logic [hvn_pkg::LEN_W-1:0]  row_length,
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output hvn_pkg::hvn_item_t              push_item
);
  import hvn_pkg::*;

  localparam int LINE_W = 2 * HEIGHT_BITS;

  // line store entry: {two rows back, one row back}
  logic [LINE_W-1:0] line_mem [MAX_ROW];
  logic [LINE_W-1:0] rd_data;

  logic [COL_W-1:0] col;
  logic [COL_W-1:0] row;

  logic             s1_valid;
  height_t          s1_h;
  logic             s1_emit;
  logic [COL_W-1:0] s1_col;
  logic [COL_W-1:0] s1_vcol;
  logic [COL_W-1:0] s1_vrow;
  logic             s1_fwd;
  logic [LINE_W-1:0] s1_fwd_data;

  logic             accept;
  logic             push;
  logic [COL_W-1:0] col0;
  logic [COL_W-1:0] row0;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] col_inc;
  logic             wrap;
  logic [LINE_W-1:0] eff_data;
  logic [LINE_W-1:0] wr_data;

  assign push     = s1_valid && push_ready;
  assign in_stall = s1_valid && !push_ready;
  assign accept   = in_valid && !in_stall;

  assign col0 = frame_start ? '0 : col;
  assign row0 = frame_start ? '0 : row;

  always_comb begin
    if (row_length < LEN_W'(MIN_LEN)) begin
      len_eff = LEN_W'(MIN_LEN);
    end else if (row_length > LEN_W'(MAX_ROW)) begin
      len_eff = LEN_W'(MAX_ROW);
    end else begin
      len_eff = row_length;
    end
  end

  assign col_inc = {{(LEN_W-COL_W){1'b0}}, col0} + LEN_W'(1);
  assign wrap    = col_inc >= len_eff;

  // the item in s1 has not written its entry yet; bypass it on a same-column read
  assign eff_data = s1_fwd ? s1_fwd_data : rd_data;
  assign wr_data  = {eff_data[HEIGHT_BITS-1:0], s1_h};

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (wrap) begin
          col <= '0;
          row <= (row0 != ROW_SAT) ? row0 + COL_W'(1) : row0;
        end else begin
          col <= col_inc[COL_W-1:0];
          row <= row0;
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_h        <= height;
      s1_col      <= col0;
      s1_emit     <= (col0 >= COL_W'(2)) && (row0 >= COL_W'(2));
      s1_vcol     <= col0 - COL_W'(1);
      s1_vrow     <= row0 - COL_W'(1);
      s1_fwd      <= s1_valid && (s1_col == col0);
      s1_fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      line_mem[s1_col] <= wr_data;
    end
    if (accept) begin
      rd_data <= line_mem[col0];
    end
  end

  assign push_valid     = s1_valid;
  assign push_item.h    = s1_h;
  assign push_item.up1  = eff_data[HEIGHT_BITS-1:0];
  assign push_item.up2  = eff_data[LINE_W-1:HEIGHT_BITS];
  assign push_item.emit = s1_emit;
  assign push_item.col  = s1_vcol;
  assign push_item.row  = s1_vrow;

endmodule
`default_nettype wire

FILE: src/hvn_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_fifo: short item queue between front and back
// Small register queue; head entry is presented while not empty.
// ----------------------------------------------------------------------------
module hvn_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire hvn_pkg::hvn_item_t push_item,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output hvn_pkg::hvn_item_t      pop_item
);
  import hvn_pkg::*;

  hvn_item_t           entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr;
  logic [FIFO_AW-1:0]  rd_ptr;
  logic [FIFO_AW:0]    count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count != (FIFO_AW+1)'(FIFO_DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (FIFO_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: src/hvn_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hvn_back: window and normal arithmetic
// Shifts the 3x3 window, forms the weighted height sums, scales by step.
// ----------------------------------------------------------------------------
module hvn_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pop_valid,
  output logic                               pop_ready,
  input  wire hvn_pkg::hvn_item_t            pop_item,
  input  wire logic [hvn_pkg::STEP_W-1:0]    step_size,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [hvn_pkg::NXZ_W-1:0]   normal_x,
  output logic signed [hvn_pkg::NY_W-1:0]    normal_y,
  output logic signed [hvn_pkg::NXZ_W-1:0]   normal_z,
  output logic [hvn_pkg::COL_W-1:0]          vertex_col,
  output logic [hvn_pkg::COL_W-1:0]          vertex_row
);
  import hvn_pkg::*;

  // win[r][c]: row 0 two rows back, column 0 two columns back
  height_t win [3][3];

  logic             adv;
  logic             pop;
  logic             v1;
  logic [COL_W-1:0] c1;
  logic [COL_W-1:0] r1;
  logic             v2;
  logic signed [SUM_W-1:0] sx2;
  logic signed [SUM_W-1:0] sz2;
  logic [COL_W-1:0] c2;
  logic [COL_W-1:0] r2;

  logic signed [SUM_W-1:0] e00, e01, e10, e11, e12, e21, e22;
  logic signed [SUM_W-1:0] sx;
  logic signed [SUM_W-1:0] sz;
  logic signed [STEP_W:0]  step_sg;
  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] pz;

  assign adv       = !out_valid || !out_stall;
  assign pop_ready = adv;
  assign pop       = pop_valid && adv;

  assign e00 = SUM_W'(win[0][0]);
  assign e01 = SUM_W'(win[0][1]);
  assign e10 = SUM_W'(win[1][0]);
  assign e11 = SUM_W'(win[1][1]);
  assign e12 = SUM_W'(win[1][2]);
  assign e21 = SUM_W'(win[2][1]);
  assign e22 = SUM_W'(win[2][2]);

  // six-face sums collapse to these; the y terms cancel exactly
  assign sx = e00 - e01 - (e10 <<< 1) + (e11 <<< 1) + e21 - e22;
  assign sz = e22 - e12 + (e01 <<< 1) - e00 + e10 - (e11 <<< 1);

  assign step_sg = $signed({1'b0, step_size});
  assign px      = sx2 * step_sg;
  assign pz      = sz2 * step_sg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (adv) begin
      v1        <= pop && pop_item.emit;
      v2        <= v1;
      out_valid <= v2;
      if (pop) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= pop_item.up2;
        win[1][2] <= pop_item.up1;
        win[2][2] <= pop_item.h;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pop) begin
        c1 <= pop_item.col;
        r1 <= pop_item.row;
      end
      sx2        <= sx;
      sz2        <= sz;
      c2         <= c1;
      r2         <= r1;
      normal_x   <= px[NXZ_W-1:0];
      normal_z   <= pz[NXZ_W-1:0];
      vertex_col <= c2;
      vertex_row <= r2;
    end
  end

  assign normal_y = '0;

endmodule
`default_nettype wire

FILE: src/heightmap_vertex_normal.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_vertex_normal: streaming terrain vertex normal generator
// Summed face normals of the six triangles around each interior grid vertex.
// ----------------------------------------------------------------------------
// Throughput: one height per cycle unless a held output fills the queue,
//   set by the single-port-read line store (one read, one write per item)
//   and a fully pipelined back end. A normal follows the height at (c+1,r+1):
//   line store read, queue, window shift, height sums, step multiply.
// Reset (rst, synchronous): counters, queue and window clear, step_size = 4,
//   row_length = 1024; line store contents stay undefined until written.
// ----------------------------------------------------------------------------
module heightmap_vertex_normal (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // height item channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [hvn_pkg::HEIGHT_BITS-1:0] height,
  input  wire logic                            frame_start,
  // normal item channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [hvn_pkg::NXZ_W-1:0]     normal_x,
  output logic signed [hvn_pkg::NY_W-1:0]      normal_y,
  output logic signed [hvn_pkg::NXZ_W-1:0]     normal_z,
  output logic [hvn_pkg::COL_W-1:0]            vertex_col,
  output logic [hvn_pkg::COL_W-1:0]            vertex_row,
  // register writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [hvn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hvn_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hvn_pkg::*;

  logic [STEP_W-1:0] step_size;
  logic [LEN_W-1:0]  row_length;

  logic      push_valid;
  logic      push_ready;
  hvn_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  hvn_item_t pop_item;

  // Registers are to be written only while the pipeline is empty; the block does not enforce it, so no hold-off.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size  <= STEP_W'(4);
      row_length <= LEN_W'(MAX_ROW);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STEP_SIZE: begin
          step_size <= cfg_data[STEP_W-1:0];
        end
        CFG_ROW_LENGTH: begin
          row_length <= cfg_data[LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front: raster counters, line store, tags border vertices as no-result.
  hvn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .height      (height),
    .frame_start (frame_start),
    .row_length  (row_length),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  // Queue: lets the front keep taking heights while the output is held.
  hvn_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back: every item shifts the window; tagged items produce a normal.
  hvn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .step_size  (step_size),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .vertex_col (vertex_col),
    .vertex_row (vertex_row)
  );

endmodule
`default_nettype wire

FILE: tb/sv/hvn_normal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_normal_checker: vertex normal scoreboard
// Follows the height and register channels and predicts the summed face normal
// of every interior vertex. Each normal the block hands out is compared with
// the oldest one still due.
// ----------------------------------------------------------------------------
module hvn_normal_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [hvn_pkg::HEIGHT_BITS-1:0] height,
  input  logic                                 frame_start,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [hvn_pkg::NXZ_W-1:0]     normal_x,
  input  logic signed [hvn_pkg::NY_W-1:0]      normal_y,
  input  logic signed [hvn_pkg::NXZ_W-1:0]     normal_z,
  input  logic [hvn_pkg::COL_W-1:0]            vertex_col,
  input  logic [hvn_pkg::COL_W-1:0]            vertex_row,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hvn_pkg::CFG_DATA_W-1:0]       cfg_data,
  output int                                   mismatch_count,
  output int                                   normals_pending
);
  import hvn_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    longint x;
    longint y;
    longint z;
  } vec3_t;

  typedef struct packed {
    logic signed [NXZ_W-1:0] nx;
    logic signed [NY_W-1:0]  ny;
    logic signed [NXZ_W-1:0] nz;
    logic [COL_W-1:0]        col;
    logic [COL_W-1:0]        row;
  } vertex_normal_t;

  logic [STEP_W-1:0] step_size;
  logic [LEN_W-1:0]  row_length;
  height_t           older_row [MAX_ROW];
  height_t           prev_row [MAX_ROW];
  height_t           win [3][3];   // [row][col], row 0 two rows back
  int                col_count;
  int                row_count;
  vertex_normal_t    normals_due [$];

  function automatic vec3_t pt(input longint x, input longint y, input longint z);
    vec3_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  // cross product (p2 - p1) x (p3 - p1), same component order as the block
  function automatic vec3_t face_normal(input vec3_t p1, input vec3_t p2, input vec3_t p3);
    vec3_t a;
    vec3_t b;
    vec3_t f;
    a = pt(p2.x - p1.x, p2.y - p1.y, p2.z - p1.z);
    b = pt(p3.x - p1.x, p3.y - p1.y, p3.z - p1.z);
    f.x = a.y * b.z - a.z * b.y;
    f.y = b.x * a.z - a.x * b.z;
    f.z = a.x * b.y - b.x * a.y;
    return f;
  endfunction

  // shift one height into the window and queue a normal for interior vertices
  function automatic void absorb_height(input height_t h, input logic fs);
    int             eff_len;
    int             k;
    height_t        up1;
    height_t        up2;
    longint         s;
    vec3_t          c, e, w, n, so, ne, sw, acc;
    vec3_t          f [6];
    vertex_normal_t vn;
    if (fs) begin
      col_count = 0;
      row_count = 0;
    end
    eff_len = int'(row_length);
    if (eff_len < MIN_LEN) eff_len = MIN_LEN;
    if (eff_len > MAX_ROW) eff_len = MAX_ROW;

    up1 = '0;
    up2 = '0;
    if (col_count < MAX_ROW) begin
      up2 = older_row[col_count];
      up1 = prev_row[col_count];
      older_row[col_count] = up1;
      prev_row[col_count]  = h;
    end
    for (k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = h;

    if (col_count >= 2 && row_count >= 2) begin
      s  = longint'(step_size);
      c  = pt(0,  longint'(win[1][1]), 0);
      e  = pt(s,  longint'(win[1][2]), 0);
      w  = pt(-s, longint'(win[1][0]), 0);
      n  = pt(0,  longint'(win[2][1]), s);
      so = pt(0,  longint'(win[0][1]), -s);
      ne = pt(s,  longint'(win[2][2]), s);
      sw = pt(-s, longint'(win[0][0]), -s);
      f[0] = face_normal(c, e, ne);
      f[1] = face_normal(c, e, so);
      f[2] = face_normal(c, so, sw);
      f[3] = face_normal(c, n, w);
      f[4] = face_normal(c, w, sw);
      f[5] = face_normal(c, n, ne);
      acc = pt(0, 0, 0);
      for (k = 0; k < 6; k++) begin
        acc.x += f[k].x;
        acc.y += f[k].y;
        acc.z += f[k].z;
      end
      vn.nx  = acc.x[NXZ_W-1:0];
      vn.ny  = acc.y[NY_W-1:0];
      vn.nz  = acc.z[NXZ_W-1:0];
      vn.col = col_count[COL_W-1:0] - 1'b1;
      vn.row = row_count[COL_W-1:0] - 1'b1;
      normals_due.push_back(vn);
    end

    if (col_count + 1 >= eff_len) begin
      col_count = 0;
      if (row_count < int'(ROW_SAT)) row_count++;
    end else begin
      col_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    vertex_normal_t want;
    int             k;
    if (rst) begin
      step_size  = STEP_W'(4);
      row_length = LEN_W'(MAX_ROW);
      for (k = 0; k < MAX_ROW; k++) begin
        older_row[k] = '0;
        prev_row[k]  = '0;
      end
      for (k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
      col_count = 0;
      row_count = 0;
      normals_due.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (normals_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: normal with none due: x=%0d y=%0d z=%0d col=%0d row=%0d",
                     $time, normal_x, normal_y, normal_z, vertex_col, vertex_row);
        end else begin
          want = normals_due.pop_front();
          if (normal_x !== want.nx || normal_y !== want.ny || normal_z !== want.nz ||
              vertex_col !== want.col || vertex_row !== want.row) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: normal mismatch: exp x=%0d y=%0d z=%0d col=%0d row=%0d, got x=%0d y=%0d z=%0d col=%0d row=%0d",
                       $time, want.nx, want.ny, want.nz, want.col, want.row,
                       normal_x, normal_y, normal_z, vertex_col, vertex_row);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEP_SIZE:  step_size  = cfg_data[STEP_W-1:0];
          CFG_ROW_LENGTH: row_length = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) absorb_height(height, frame_start);
    end
    normals_pending <= normals_due.size();
  end

endmodule

FILE: tb/sv/tb_heightmap_vertex_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heightmap_vertex_normal: testbench top for the vertex normal block
// Streams height grids under changing step and row length settings, with
// bursty input and a stalling receiver; hvn_normal_checker does the scoring.
// ----------------------------------------------------------------------------
module tb_heightmap_vertex_normal;
  import hvn_pkg::*;

  localparam int     HALF_PERIOD  = 10;       // 20 ns clock
  localparam int     RESET_CYCLES = 9;
  localparam int     SETTLE       = 8;        // slack for trailing items to drain
  localparam int     RANDOM_ITEMS = 1600;
  localparam longint RUN_LIMIT_NS = 40_000_000;

  typedef enum int {HS_NOISE, HS_EXTREME, HS_WALK} height_style_t;
  typedef enum int {ST_NONE, ST_LIGHT, ST_HEAVY, ST_PERIODIC} stall_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic signed [HEIGHT_BITS-1:0] height     = '0;
  logic                         frame_start = 1'b0;

  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic signed [NXZ_W-1:0]      normal_x;
  logic signed [NY_W-1:0]       normal_y;
  logic signed [NXZ_W-1:0]      normal_z;
  logic [COL_W-1:0]             vertex_col;
  logic [COL_W-1:0]             vertex_row;

  logic                         cfg_valid   = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index   = CFG_STEP_SIZE;
  logic [CFG_DATA_W-1:0]        cfg_data    = '0;

  int mismatch_count;
  int normals_pending;

  int          items_sent = 0;
  int          burst_left = 0;
  int          grid_len   = MAX_ROW;   // effective length the current grid started with
  stall_mode_t stall_mode = ST_NONE;
  logic [7:0]  stall_tick = '0;

  // rows of three: checkerboards of the extremes, flat rows, alternating bits
  int corner_heights [24] = '{
    255, -256, 255,
    -256, 255, -256,
    255, -256, 255,
    -256, -256, -256,
    255, 255, 255,
    0, 0, 0,
    -1, 1, -255,
    170, -171, 85
  };

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  heightmap_vertex_normal u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .height      (height),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .vertex_col  (vertex_col),
    .vertex_row  (vertex_row),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  hvn_normal_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .height          (height),
    .frame_start     (frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .normal_x        (normal_x),
    .normal_y        (normal_y),
    .normal_z        (normal_z),
    .vertex_col      (vertex_col),
    .vertex_row      (vertex_row),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .normals_pending (normals_pending)
  );

  // Receiver: stall mode is redrawn each time the 8-bit tick counter wraps, so
  // some windows never stall and others hold the output back most of the time.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_tick <= '0;
      stall_mode <= ST_NONE;
    end else begin
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick == '1) stall_mode <= stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        ST_NONE:  out_stall <= 1'b0;
        ST_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        ST_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= stall_tick[2] & stall_tick[0];
      endcase
    end
  end

  function automatic int clamp_len(input int l);
    if (l < MIN_LEN) return MIN_LEN;
    if (l > MAX_ROW) return MAX_ROW;
    return l;
  endfunction

  function automatic height_t next_height(input height_style_t style, input height_t last);
    int v;
    case (style)
      HS_NOISE: v = int'(height_t'($urandom));
      HS_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       v = -256;
          1:       v = -255;
          2:       v = 255;
          3:       v = 0;
          4:       v = -1;
          default: v = 1;
        endcase
      end
      default: begin
        // gentle slope, clipped to the field
        v = int'(last) + int'($urandom_range(0, 16)) - 8;
        if (v > 255) v = 255;
        if (v < -256) v = -256;
      end
    endcase
    return height_t'(v);
  endfunction

  // One height item. The sender runs in bursts; between bursts in_valid drops
  // for a random gap. A zero gap keeps valid high so it is never toggled twice.
  task automatic send_height(input height_t h, input logic fs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid    <= 1'b1;
    height      <= h;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Wait for every predicted normal, then let trailing border items flush out
  // of the pipeline before registers change.
  task automatic quiesce();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (normals_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // holds cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // upper data bits of a step write are don't-care, so they are randomized
  task automatic program_regs(input bit with_step, input int step_val, input int len_val);
    if (with_step)
      write_reg(CFG_STEP_SIZE, {4'($urandom), 7'(step_val)});
    write_reg(CFG_ROW_LENGTH, CFG_DATA_W'(len_val));
    cfg_valid <= 1'b0;
  endtask

  // One run of heights at the current settings. restart puts frame_start on
  // the first item; fs_odds > 0 sprinkles extra grid restarts in between.
  task automatic run_grid(input int n_items, input bit restart, input int fs_odds);
    height_style_t style;
    height_t       h;
    logic          fs;
    int            i;
    style = height_style_t'($urandom_range(0, 2));
    h = '0;
    for (i = 0; i < n_items; i++) begin
      h  = next_height(style, h);
      fs = (i == 0 && restart) || (fs_odds > 0 && $urandom_range(1, fs_odds) == 1);
      send_height(h, fs);
    end
  endtask

  initial begin
    int goal;
    int step_val;
    int len_val;
    int eff;
    int n_items;
    bit restart;
    int i;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: step left at its reset value, row length 0 behaves as 3, so
    // every row has one interior vertex. Extremes and alternating bit patterns.
    program_regs(1'b0, 0, 0);
    grid_len = MIN_LEN;
    for (i = 0; i < 24; i++) send_height(height_t'(corner_heights[i]), i == 0);
    quiesce();

    // Row length lowered mid-row: 29 items of 8 leave the column count at 5,
    // so the first item after the write to 4 ends that row at once.
    program_regs(1'b1, $urandom_range(0, 127), 8);
    run_grid(29, 1'b1, 0);
    quiesce();
    program_regs(1'b1, 127, 4);
    run_grid(20, 1'b0, 0);
    grid_len = 4;
    quiesce();

    // Random phases. A grid may shrink without a restart, but a longer row
    // always starts a new grid so no unwritten line store entry gets read.
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      case ($urandom_range(0, 5))
        0:       step_val = 0;
        1:       step_val = 1;
        2:       step_val = 64;
        3:       step_val = 127;
        default: step_val = $urandom_range(0, 127);
      endcase
      case ($urandom_range(0, 7))
        0:       len_val = $urandom_range(0, 2);
        6:       len_val = $urandom_range(25, 96);
        7:       len_val = $urandom_range(97, 200);
        default: len_val = $urandom_range(3, 24);
      endcase
      eff     = clamp_len(len_val);
      restart = (eff > grid_len) || ($urandom_range(0, 1) == 1);
      grid_len = eff;
      n_items = 3 * eff + $urandom_range(1, 150);
      program_regs(1'b1, step_val, len_val);
      run_grid(n_items, restart, ($urandom_range(0, 1) == 1) ? 200 : 0);
      quiesce();
    end

    // Widest rows: a length above the maximum acts as the maximum.
    program_regs(1'b1, $urandom_range(0, 127), 2047);
    grid_len = MAX_ROW;
    run_grid(3 * MAX_ROW + 40, 1'b1, 0);
    quiesce();

    // Long grid of 3-wide rows: the row count saturates and later normals
    // keep reporting the last row number.
    program_regs(1'b1, 64, 2);
    grid_len = MIN_LEN;
    run_grid(3 * 1030, 1'b1, 0);
    quiesce();

    if (mismatch_count == 0) begin
      $display("tb_heightmap_vertex_normal: clean");
    end else begin
      $display("tb_heightmap_vertex_normal: errors");
    end
    $finish;
  end

  // watchdog for a hung handshake or a normal that never comes out
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_heightmap_vertex_normal: errors");
    $finish;
  end

endmodule
